// ===== rtl/core/dlsc_pkg.sv =====
// ----------------------------------------------------------------------------
// dlsc_pkg
// shared types and constants of the dashboard link session controller
// ----------------------------------------------------------------------------
package dlsc_pkg;

   typedef enum logic [2:0] {
      OP_START    = 3'd0,
      OP_STOP     = 3'd1,
      OP_FRAMES   = 3'd2,
      OP_TICK     = 3'd3,
      OP_ACCEPTED = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      PH_OFF     = 2'd0,
      PH_STARTUP = 2'd1,
      PH_ACTIVE  = 2'd2,
      PH_GAP     = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      TX_NONE    = 2'd0,
      TX_STOP    = 2'd1,
      TX_REQUEST = 2'd2,
      TX_LIGHT   = 2'd3
   } tx_kind_type;

   typedef enum logic [1:0] {
      CSR_STARTUP_TIMEOUT = 2'd0,
      CSR_RECEIVE_GAP     = 2'd1,
      CSR_RETRY           = 2'd2
   } csr_index_type;

   localparam int unsigned QUEUE_DEPTH = 8;
   localparam int unsigned QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QCOUNT_W-1:0] QUEUE_DEPTH_Q = QCOUNT_W'(QUEUE_DEPTH);

   localparam logic [15:0] STARTUP_TIMEOUT_RESET = 16'd800;
   localparam logic [15:0] RECEIVE_GAP_RESET     = 16'd400;
   localparam logic [15:0] RETRY_RESET           = 16'd800;

   localparam logic [7:0] SOF_BYTE       = 8'hF5;
   localparam logic [7:0] LIGHT_CMD      = 8'hA1;
   localparam logic [7:0] SHORT_CMD      = 8'h01;
   localparam logic [7:0] LIGHT_LEN      = 8'h02;
   localparam logic [7:0] SHORT_LEN      = 8'h01;
   localparam logic [7:0] LIGHT_SUB      = 8'h01;
   localparam logic [7:0] REQUEST_CODE   = 8'h04;
   localparam logic [7:0] STOP_CODE      = 8'h00;
   localparam logic [2:0] LIGHT_FRAME_LEN = 3'd6;
   localparam logic [2:0] SHORT_FRAME_LEN = 3'd5;

   typedef struct packed {
      logic [2:0]      length;
      logic [5:0][7:0] data;
   } frame_type;

endpackage

// ===== rtl/core/dlsc_frame_build.sv =====
// ----------------------------------------------------------------------------
// dlsc_frame_build
// forms the pending frame bytes and xor check byte from the frame kind
// ----------------------------------------------------------------------------
module dlsc_frame_build
   import dlsc_pkg::*;
(
   input  tx_kind_type kind,
   input  logic [3:0]  bright_idx,
   output frame_type   frame
);

   logic [7:0] code;

   always_comb begin
      code  = (kind == TX_REQUEST) ? REQUEST_CODE : STOP_CODE;
      frame = '0;
      unique case (kind)
         TX_LIGHT: begin
            frame.length  = LIGHT_FRAME_LEN;
            frame.data[0] = SOF_BYTE;
            frame.data[1] = LIGHT_CMD;
            frame.data[2] = LIGHT_LEN;
            frame.data[3] = LIGHT_SUB;
            frame.data[4] = {4'd0, bright_idx};
            frame.data[5] = SOF_BYTE ^ LIGHT_CMD ^ LIGHT_LEN ^ LIGHT_SUB ^ {4'd0, bright_idx};
         end
         TX_STOP, TX_REQUEST: begin
            frame.length  = SHORT_FRAME_LEN;
            frame.data[0] = SOF_BYTE;
            frame.data[1] = SHORT_CMD;
            frame.data[2] = SHORT_LEN;
            frame.data[3] = code;
            frame.data[4] = SOF_BYTE ^ SHORT_CMD ^ SHORT_LEN ^ code;
         end
         TX_NONE: begin
            frame = '0;
         end
      endcase
   end

endmodule

// ===== rtl/core/dash_link_session_control_core.sv =====
// ----------------------------------------------------------------------------
// dash_link_session_control_core
// pipeline: request register then result register
// throughput: one word per cycle while rsp_ready does not stall the result
// register, set by the single update pass on the session registers between the two registers
// reset: synchronous; phase startup, flags and counters cleared,
// timeouts back to 800, 400 and 800 ms
// ----------------------------------------------------------------------------
module dash_link_session_control_core
   import dlsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_now_ms,
   input  logic [15:0] req_frame_count,
   input  logic [1:0]  req_accepted_kind,
   input  logic [3:0]  req_bright_idx,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_tx_kind,
   output logic [2:0]  rsp_frame_length,
   output logic [7:0]  rsp_byte_0,
   output logic [7:0]  rsp_byte_1,
   output logic [7:0]  rsp_byte_2,
   output logic [7:0]  rsp_byte_3,
   output logic [7:0]  rsp_byte_4,
   output logic [7:0]  rsp_byte_5,
   output logic [1:0]  rsp_link_phase,
   output logic [3:0]  rsp_queued_replies,
   output logic [31:0] rsp_overflow_total,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   // configuration
   logic [15:0] startup_timeout_ff, receive_gap_ff, retry_ff;

   // request register
   logic        in_valid_ff;
   logic [2:0]  in_op_ff;
   logic [31:0] in_now_ff;
   logic [15:0] in_count_ff;
   logic [1:0]  in_acc_ff;
   logic [3:0]  in_idx_ff;

   // session state
   phase_type           phase_ff, phase_in;
   logic [31:0]         phase_start_ff, phase_start_in;
   logic                frames_heard_ff, frames_heard_in;
   logic [1:0]          group_rem_ff, group_rem_in;
   logic                request_ff, request_in;
   logic                stop_ff, stop_in;
   logic [QCOUNT_W-1:0] pending_ff, pending_in;
   logic [31:0]         dropped_ff, dropped_in;

   // result register
   logic                out_valid_ff;
   tx_kind_type         out_kind_ff;
   frame_type           out_frame_ff;
   phase_type           out_phase_ff;
   logic [QCOUNT_W-1:0] out_pending_ff;
   logic [31:0]         out_dropped_ff;

   logic                advance;
   tx_kind_type         kind_in;
   frame_type           frame_in;
   logic [31:0]         age;
   logic [2:0]          rest;
   logic [14:0]         replies;
   logic [QCOUNT_W-1:0] room;
   logic                overfull;

   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         startup_timeout_ff <= STARTUP_TIMEOUT_RESET;
         receive_gap_ff     <= RECEIVE_GAP_RESET;
         retry_ff           <= RETRY_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STARTUP_TIMEOUT: startup_timeout_ff <= csr_data;
            CSR_RECEIVE_GAP:     receive_gap_ff     <= csr_data;
            CSR_RETRY:           retry_ff           <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff    <= req_op;
         in_now_ff   <= req_now_ms;
         in_count_ff <= req_frame_count;
         in_acc_ff   <= req_accepted_kind;
         in_idx_ff   <= req_bright_idx;
      end
   end

   // frame grouping and queue room
   always_comb begin
      age      = in_now_ff - phase_start_ff;
      rest     = {1'b0, in_count_ff[1:0]} + {1'b0, group_rem_ff};
      replies  = {1'b0, in_count_ff[15:2]} + {14'd0, rest[2]};
      room     = (pending_ff >= QUEUE_DEPTH_Q) ? '0 : QUEUE_DEPTH_Q - pending_ff;
      overfull = replies > 15'(room);
   end

   always_comb begin
      phase_in        = phase_ff;
      phase_start_in  = phase_start_ff;
      frames_heard_in = frames_heard_ff;
      group_rem_in    = group_rem_ff;
      request_in      = request_ff;
      stop_in         = stop_ff;
      pending_in      = pending_ff;
      dropped_in      = dropped_ff;
      unique case (in_op_ff)
         OP_START: begin
            phase_in        = PH_STARTUP;
            phase_start_in  = in_now_ff;
            frames_heard_in = 1'b0;
            group_rem_in    = '0;
            request_in      = 1'b0;
            pending_in      = '0;
            stop_in         = 1'b0;
         end
         OP_STOP: begin
            phase_in        = PH_OFF;
            frames_heard_in = 1'b0;
            group_rem_in    = '0;
            pending_in      = '0;
            request_in      = 1'b0;
            stop_in         = 1'b1;
         end
         OP_FRAMES: begin
            if (in_count_ff != '0 && phase_ff == PH_ACTIVE && !request_ff) begin
               frames_heard_in = 1'b1;
               phase_start_in  = in_now_ff;
               group_rem_in    = rest[1:0];
               if (overfull) begin
                  dropped_in = dropped_ff + 32'(replies - 15'(room));
                  pending_in = pending_ff + room;
               end else begin
                  pending_in = pending_ff + QCOUNT_W'(replies);
               end
            end
         end
         OP_TICK: begin
            if (!request_ff && !stop_ff) begin
               priority if (phase_ff == PH_STARTUP && age > 32'(startup_timeout_ff)) begin
                  frames_heard_in = 1'b0;
                  group_rem_in    = '0;
                  pending_in      = '0;
                  stop_in         = 1'b0;
                  request_in      = 1'b1;
               end else if (phase_ff == PH_ACTIVE && age > 32'(receive_gap_ff)) begin
                  phase_in        = PH_GAP;
                  phase_start_in  = in_now_ff;
                  frames_heard_in = 1'b0;
                  pending_in      = '0;
               end else if (phase_ff == PH_GAP && age > 32'(retry_ff)) begin
                  frames_heard_in = 1'b0;
                  group_rem_in    = '0;
                  pending_in      = '0;
                  stop_in         = 1'b0;
                  request_in      = 1'b1;
               end else begin
               end
            end
         end
         OP_ACCEPTED: begin
            unique case (in_acc_ff)
               TX_REQUEST: begin
                  request_in      = 1'b0;
                  phase_in        = PH_ACTIVE;
                  phase_start_in  = in_now_ff;
                  group_rem_in    = '0;
                  frames_heard_in = 1'b0;
               end
               TX_LIGHT: begin
                  if (pending_ff != '0) begin
                     pending_in = pending_ff - QCOUNT_W'(1);
                  end
               end
               TX_STOP: begin
                  stop_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      priority if (stop_in) begin
         kind_in = TX_STOP;
      end else if (request_in) begin
         kind_in = TX_REQUEST;
      end else if (pending_in != '0) begin
         kind_in = TX_LIGHT;
      end else begin
         kind_in = TX_NONE;
      end
   end

   dlsc_frame_build u_frame_build (
      .kind       (kind_in),
      .bright_idx (in_idx_ff),
      .frame      (frame_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_STARTUP;
         phase_start_ff  <= '0;
         frames_heard_ff <= 1'b0;
         group_rem_ff    <= '0;
         request_ff      <= 1'b0;
         stop_ff         <= 1'b0;
         pending_ff      <= '0;
         dropped_ff      <= '0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         phase_start_ff  <= phase_start_in;
         frames_heard_ff <= frames_heard_in;
         group_rem_ff    <= group_rem_in;
         request_ff      <= request_in;
         stop_ff         <= stop_in;
         pending_ff      <= pending_in;
         dropped_ff      <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_kind_ff    <= kind_in;
         out_frame_ff   <= frame_in;
         out_phase_ff   <= phase_in;
         out_pending_ff <= pending_in;
         out_dropped_ff <= dropped_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_tx_kind        = out_kind_ff;
   assign rsp_frame_length   = out_frame_ff.length;
   assign rsp_byte_0         = out_frame_ff.data[0];
   assign rsp_byte_1         = out_frame_ff.data[1];
   assign rsp_byte_2         = out_frame_ff.data[2];
   assign rsp_byte_3         = out_frame_ff.data[3];
   assign rsp_byte_4         = out_frame_ff.data[4];
   assign rsp_byte_5         = out_frame_ff.data[5];
   assign rsp_link_phase     = out_phase_ff;
   assign rsp_queued_replies = 4'(out_pending_ff);
   assign rsp_overflow_total = out_dropped_ff;

endmodule

// ===== rtl/core/dlsc_checker.sv =====
// ----------------------------------------------------------------------------
// dlsc_checker
// port level checks on the result words of the session controller
// ----------------------------------------------------------------------------
module dlsc_checker
   import dlsc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_tx_kind,
   input logic [2:0]  rsp_frame_length,
   input logic [7:0]  rsp_byte_0,
   input logic [7:0]  rsp_byte_1,
   input logic [7:0]  rsp_byte_2,
   input logic [7:0]  rsp_byte_3,
   input logic [7:0]  rsp_byte_4,
   input logic [7:0]  rsp_byte_5,
   input logic [3:0]  rsp_queued_replies,
   input logic [31:0] rsp_overflow_total
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_kind)
         && $stable(rsp_overflow_total) && $stable(rsp_byte_4))
      else $error("result word changed while stalled");

   // empty word carries no frame
   a_none_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_kind == TX_NONE |-> rsp_frame_length == 3'd0
         && rsp_byte_0 == 8'd0 && rsp_byte_4 == 8'd0 && rsp_byte_5 == 8'd0)
      else $error("frame bytes without pending frame");

   // light frame sums to zero
   a_light_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tx_kind == TX_LIGHT |-> rsp_frame_length == LIGHT_FRAME_LEN
         && (rsp_byte_0 ^ rsp_byte_1 ^ rsp_byte_2 ^ rsp_byte_3 ^ rsp_byte_4
             ^ rsp_byte_5) == 8'd0 && rsp_queued_replies != 4'd0)
      else $error("bad light frame");

   // short frames sum to zero
   a_short_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tx_kind == TX_STOP || rsp_tx_kind == TX_REQUEST)
         |-> rsp_frame_length == SHORT_FRAME_LEN && rsp_byte_5 == 8'd0
         && (rsp_byte_0 ^ rsp_byte_1 ^ rsp_byte_2 ^ rsp_byte_3 ^ rsp_byte_4) == 8'd0)
      else $error("bad short frame");

   // queue never above its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_queued_replies) <= QUEUE_DEPTH)
      else $error("reply queue above depth");

endmodule

bind dash_link_session_control_core dlsc_checker u_dlsc_checker (.*);
